// ===== rtl/core/gdrle_pkg.sv =====
// shared types and constants for the dictionary run-length pixel decompressor
// no dependencies; imported by graphics_dictionary_rle_decompressor
`default_nettype none

package gdrle_pkg;

   localparam int BYTE_W        = 8;
   localparam int PAIR_W        = 16;
   localparam int LEN_W         = 20;
   localparam int SLOT_W        = 4;
   localparam int BYTE_VALUES   = 1 << BYTE_W;
   localparam int DICT_ENTRIES_DEF = 256;
   localparam int OUT_DEPTH     = 4;

   localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(4);
   localparam logic [SLOT_W-1:0] FLAG_SLOTS = SLOT_W'(8);

   // request action codes
   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_CODE  = 2'd2
   } action_type;

   // one result item
   typedef struct packed {
      logic [BYTE_W-1:0] pixel_value;
      logic [BYTE_W-1:0] repeat_count;
      logic              last_of_item;
      logic              decode_done;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/graphics_dictionary_rle_decompressor.sv =====
// dictionary run-length pixel decompressor, top level
// depends on gdrle_pkg (types, widths, action codes)
`default_nettype none

// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-------------------------------------------
// req       | in        | req_valid / req_ready | action, entry_index, entry_pair, code_byte
// rsp       | out       | rsp_valid / rsp_ready | pixel_value, repeat_count, last_of_item,
//           |           |                       | decode_done
// csr       | in        | csr_valid / csr_ready | output_length
//
// an item is taken into the decode stage at accept; the dictionary ram is read at the same edge
// and its data is registered. the decode stage handles a literal, flag, load or start item whole
// and a dictionary index item symbol by symbol, low byte then high byte (one symbol per cycle
// through a single symbol unit). results enter a 4-deep output queue and appear in the next
// cycle; the decode stage holds while the queue has fewer than two free places. no clearing
// pass after reset: a dictionary entry read before it is written is outside the contract.

module graphics_dictionary_rle_decompressor #(
   parameter int DICT_ENTRIES = gdrle_pkg::DICT_ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [1:0]                     req_action,
   input  wire logic [gdrle_pkg::BYTE_W-1:0]   req_entry_index,
   input  wire logic [gdrle_pkg::PAIR_W-1:0]   req_entry_pair,
   input  wire logic [gdrle_pkg::BYTE_W-1:0]   req_code_byte,

   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [gdrle_pkg::BYTE_W-1:0]   rsp_pixel_value,
   output      logic [gdrle_pkg::BYTE_W-1:0]   rsp_repeat_count,
   output      logic                           rsp_last_of_item,
   output      logic                           rsp_decode_done,

   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [gdrle_pkg::LEN_W-1:0]    csr_output_length
);

   import gdrle_pkg::*;

   localparam int IDX_BITS = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
   localparam logic [BYTE_W:0] ENTRIES_LIMIT = (BYTE_W+1)'(DICT_ENTRIES);
   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(OUT_DEPTH - 2);

   // ---------------------------------------------------------------------------------------
   // index byte to dictionary address, wrapping at the dictionary size
   // ---------------------------------------------------------------------------------------
   logic [IDX_BITS-1:0] idx_lut [BYTE_VALUES];

   for (genvar gi = 0; gi < BYTE_VALUES; gi++) begin : g_idx_lut
      assign idx_lut[gi] = IDX_BITS'(gi % DICT_ENTRIES);
   end

   // ---------------------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------------------
   logic [LEN_W-1:0]  len_ff;

   // decode stage: the item being worked on
   logic              b_valid_ff,  b_valid_in;
   action_type        b_action_ff;
   logic [BYTE_W-1:0] b_code_ff;
   logic              b_phase_ff,  b_phase_in;   // second symbol of an index pair

   // dictionary ram and its registered read data
   logic [PAIR_W-1:0] dict_mem [DICT_ENTRIES];
   logic [PAIR_W-1:0] rd_ff;

   // decode state
   logic [BYTE_W-1:0] flag_ff,     flag_in;
   logic [SLOT_W-1:0] slots_ff,    slots_in;
   logic              cp_ff,       cp_in;        // next symbol is a repeat count
   logic [BYTE_W-1:0] prev_ff,     prev_in;
   logic              pv_ff,       pv_in;
   logic [LEN_W-1:0]  prod_ff,     prod_in;
   logic              fin_ff,      fin_in;

   // first result of an index pair waits here until the second symbol is known
   rsp_item_type      hold_ff,     hold_in;
   logic              hold_v_ff,   hold_v_in;

   // output queue
   rsp_item_type      oq_ff [OUT_DEPTH];
   logic [PTR_W-1:0]  wp_ff,       wp_in;
   logic [PTR_W-1:0]  rp_ff,       rp_in;
   logic [CNT_W-1:0]  cnt_ff,      cnt_in;

   // ---------------------------------------------------------------------------------------
   // symbol unit: when the decode stage is not held, one symbol per cycle
   // ---------------------------------------------------------------------------------------
   logic [BYTE_W-1:0] sym;
   logic [BYTE_W-1:0] copies;
   logic [LEN_W:0]    room;
   logic              no_room;
   logic              clip;
   logic              emit_try;
   logic              res_v;
   rsp_item_type      res;
   logic              sym_fin;
   logic [LEN_W-1:0]  sym_prod;
   logic              sym_cp;
   logic [BYTE_W-1:0] sym_prev;
   logic              sym_pv;

   always_comb begin
      // low byte of the pair, high byte, or the literal itself
      if (b_phase_ff) begin
         sym = rd_ff[PAIR_W-1:BYTE_W];
      end else if (flag_ff[BYTE_W-1]) begin
         sym = rd_ff[BYTE_W-1:0];
      end else begin
         sym = b_code_ff;
      end

      copies   = cp_ff ? (sym + BYTE_W'(1)) : BYTE_W'(1);
      room     = {1'b0, len_ff} - {1'b0, prod_ff};
      no_room  = room[LEN_W] || (room == '0);
      clip     = {{(LEN_W-BYTE_W){1'b0}}, copies} >= room[LEN_W-1:0];
      emit_try = !fin_ff && (copies != '0);
      res_v    = emit_try && !no_room;

      sym_fin  = fin_ff || (emit_try && (no_room || clip));
      sym_prod = prod_ff;
      if (res_v) begin
         sym_prod = clip ? len_ff : (prod_ff + LEN_W'(copies));
      end

      res.pixel_value  = cp_ff ? prev_ff : sym;
      res.repeat_count = clip ? room[BYTE_W-1:0] : copies;
      res.last_of_item = 1'b1;
      res.decode_done  = sym_fin;

      // repeat-count symbols leave the previous pixel alone
      sym_cp   = cp_ff;
      sym_prev = prev_ff;
      sym_pv   = pv_ff;
      if (!fin_ff) begin
         if (cp_ff) begin
            sym_cp = 1'b0;
         end else begin
            sym_cp   = pv_ff && (sym == prev_ff);
            sym_prev = sym;
            sym_pv   = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // decode stage control
   // ---------------------------------------------------------------------------------------
   logic              space_ok;
   logic              b_fire;
   logic              b_last;
   logic              item_done;
   logic              accept;
   logic              load_ok;
   logic              pop;
   logic [1:0]        push_cnt;
   rsp_item_type      e0;
   rsp_item_type      e1;

   assign space_ok  = cnt_ff <= ROOM_LIMIT;
   assign b_fire    = b_valid_ff && space_ok;
   // only the first half of an index pair keeps the item in the stage
   assign b_last    = !((b_action_ff == ACT_CODE) && !fin_ff && (slots_ff != '0) &&
                        !b_phase_ff && flag_ff[BYTE_W-1]);
   assign item_done = b_fire && b_last;
   assign req_ready = !reset && (!b_valid_ff || item_done);
   assign accept    = req_valid && req_ready;
   assign load_ok   = (req_action == ACT_LOAD) && ({1'b0, req_entry_index} < ENTRIES_LIMIT);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      flag_in    = flag_ff;
      slots_in   = slots_ff;
      cp_in      = cp_ff;
      prev_in    = prev_ff;
      pv_in      = pv_ff;
      prod_in    = prod_ff;
      fin_in     = fin_ff;
      hold_in    = hold_ff;
      hold_v_in  = hold_v_ff;
      b_phase_in = b_phase_ff;
      push_cnt   = 2'd0;
      e0         = res;
      e1         = res;

      if (b_fire) begin
         case (b_action_ff)
            ACT_START: begin
               flag_in  = '0;
               slots_in = '0;
               cp_in    = 1'b0;
               prev_in  = '0;
               pv_in    = 1'b0;
               prod_in  = '0;
               fin_in   = 1'b0;
            end
            ACT_CODE: begin
               if (b_phase_ff) begin
                  // second symbol; the held result goes out even if the first one ended the decode
                  cp_in      = sym_cp;
                  prev_in    = sym_prev;
                  pv_in      = sym_pv;
                  prod_in    = sym_prod;
                  fin_in     = sym_fin;
                  b_phase_in = 1'b0;
                  hold_v_in  = 1'b0;
                  if (hold_v_ff) begin
                     e0              = hold_ff;
                     e0.last_of_item = !res_v;
                     e1              = res;
                     push_cnt        = res_v ? 2'd2 : 2'd1;
                  end else begin
                     push_cnt = {1'b0, res_v};
                  end
               end else if (!fin_ff) begin
                  if (slots_ff == '0) begin
                     // flag byte
                     flag_in  = b_code_ff;
                     slots_in = FLAG_SLOTS;
                  end else begin
                     cp_in    = sym_cp;
                     prev_in  = sym_prev;
                     pv_in    = sym_pv;
                     prod_in  = sym_prod;
                     fin_in   = sym_fin;
                     flag_in  = {flag_ff[BYTE_W-2:0], 1'b0};
                     slots_in = slots_ff - SLOT_W'(1);
                     if (flag_ff[BYTE_W-1]) begin
                        hold_in    = res;
                        hold_v_in  = res_v;
                        b_phase_in = 1'b1;
                     end else begin
                        push_cnt = {1'b0, res_v};
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (accept) begin
         b_valid_in = 1'b1;
      end else if (item_done) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end

      wp_in  = wp_ff + PTR_W'(push_cnt);
      rp_in  = rp_ff + PTR_W'(pop);
      cnt_in = cnt_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   // ---------------------------------------------------------------------------------------
   // dictionary ram: written by loads, read for every accepted item
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept && load_ok) begin
         dict_mem[req_entry_index[IDX_BITS-1:0]] <= req_entry_pair;
      end
      if (accept) begin
         rd_ff <= dict_mem[idx_lut[req_code_byte]];
      end
   end

   // ---------------------------------------------------------------------------------------
   // state registers
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= LEN_RESET;
         b_valid_ff <= 1'b0;
         b_phase_ff <= 1'b0;
         flag_ff    <= '0;
         slots_ff   <= '0;
         cp_ff      <= 1'b0;
         prev_ff    <= '0;
         pv_ff      <= 1'b0;
         prod_ff    <= '0;
         fin_ff     <= 1'b0;
         hold_v_ff  <= 1'b0;
         wp_ff      <= '0;
         rp_ff      <= '0;
         cnt_ff     <= '0;
      end else begin
         if (csr_valid) begin
            len_ff <= csr_output_length;
         end
         b_valid_ff <= b_valid_in;
         b_phase_ff <= b_phase_in;
         flag_ff    <= flag_in;
         slots_ff   <= slots_in;
         cp_ff      <= cp_in;
         prev_ff    <= prev_in;
         pv_ff      <= pv_in;
         prod_ff    <= prod_in;
         fin_ff     <= fin_in;
         hold_v_ff  <= hold_v_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         cnt_ff     <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         b_action_ff <= action_type'(req_action);
         b_code_ff   <= req_code_byte;
      end
      hold_ff <= hold_in;
      if (push_cnt != 2'd0) begin
         oq_ff[wp_ff] <= e0;
      end
      if (push_cnt == 2'd2) begin
         oq_ff[wp_ff + PTR_W'(1)] <= e1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // outputs
   // ---------------------------------------------------------------------------------------
   assign csr_ready        = !reset;
   assign rsp_valid        = cnt_ff != '0;
   assign rsp_pixel_value  = oq_ff[rp_ff].pixel_value;
   assign rsp_repeat_count = oq_ff[rp_ff].repeat_count;
   assign rsp_last_of_item = oq_ff[rp_ff].last_of_item;
   assign rsp_decode_done  = oq_ff[rp_ff].decode_done;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for graphics_dictionary_rle_decompressor
// needs gdrle_pkg and the decompressor top level; predicts every pixel run in-line

module tb_top;
   import gdrle_pkg::*;

   localparam int               DICT_SIZE    = DICT_ENTRIES_DEF;
   localparam logic [1:0]       ACT_UNUSED   = 2'd3;
   localparam logic [LEN_W-1:0] LEN_MIN      = LEN_W'(4);
   localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(1048572);
   localparam int               ITEM_TARGET  = 1050;
   // decode step, symbol unit and output queue, with margin
   localparam int               DRAIN_CYCLES = 12;
   localparam int               IDLE_LIMIT   = 4000;

   // receiver stall modes
   localparam int STALL_NONE   = 0;
   localparam int STALL_COIN   = 1;
   localparam int STALL_SPARSE = 2;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;

   logic                req_valid         = 1'b0;
   logic                req_ready;
   logic [1:0]          req_action        = ACT_START;
   logic [BYTE_W-1:0]   req_entry_index   = '0;
   logic [PAIR_W-1:0]   req_entry_pair    = '0;
   logic [BYTE_W-1:0]   req_code_byte     = '0;

   logic                rsp_valid;
   logic                rsp_ready         = 1'b0;
   logic [BYTE_W-1:0]   rsp_pixel_value;
   logic [BYTE_W-1:0]   rsp_repeat_count;
   logic                rsp_last_of_item;
   logic                rsp_decode_done;

   logic                csr_valid         = 1'b0;
   logic                csr_ready;
   logic [LEN_W-1:0]    csr_output_length = LEN_RESET;

   graphics_dictionary_rle_decompressor #(
      .DICT_ENTRIES (DICT_SIZE)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_entry_pair    (req_entry_pair),
      .req_code_byte     (req_code_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_decode_done   (rsp_decode_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_output_length (csr_output_length)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // decoder shadow state, updated at the edge where an item is accepted
   // ---------------------------------------------------------------------
   logic [PAIR_W-1:0]   pair_table [DICT_SIZE];
   logic [BYTE_W-1:0]   flag_shift;
   logic [SLOT_W-1:0]   slots_remaining;
   logic                run_count_next;     // next symbol is a repeat count
   logic [BYTE_W-1:0]   last_pixel;
   logic                last_pixel_seen;
   logic [LEN_W-1:0]    pixels_out;
   logic                decode_finished;
   logic [LEN_W-1:0]    out_length = LEN_RESET;

   rsp_item_type        item_runs[$];       // runs caused by the item being predicted
   rsp_item_type        pixel_runs_due[$];  // runs still to come out of the block

   int                  items_counted = 0;
   int                  mismatch_count = 0;
   int                  burst_left = 0;

   function automatic void clear_decode_state();
      flag_shift      = '0;
      slots_remaining = '0;
      run_count_next  = 1'b0;
      last_pixel      = '0;
      last_pixel_seen = 1'b0;
      pixels_out      = '0;
      decode_finished = 1'b0;
   endfunction

   // one run of copies, clipped at the configured length
   function automatic void emit_run(logic [BYTE_W-1:0] value, int unsigned copies);
      int unsigned  room;
      rsp_item_type run;
      if (decode_finished || copies == 0)
         return;
      // length already reached, e.g. lowered while a decode was open
      if (out_length <= pixels_out) begin
         decode_finished = 1'b1;
         return;
      end
      room = out_length - pixels_out;
      if (copies > room)
         copies = room;
      pixels_out = pixels_out + LEN_W'(copies);
      if (copies == room)
         decode_finished = 1'b1;
      run.pixel_value  = value;
      run.repeat_count = BYTE_W'(copies);
      run.last_of_item = 1'b0;
      run.decode_done  = decode_finished;
      item_runs.push_back(run);
   endfunction

   function automatic void feed_symbol(logic [BYTE_W-1:0] sym);
      if (decode_finished)
         return;
      if (run_count_next) begin
         // count of 0xff wraps to zero extra copies
         run_count_next = 1'b0;
         emit_run(last_pixel, (int'(sym) + 1) % BYTE_VALUES);
         return;
      end
      emit_run(sym, 1);
      if (last_pixel_seen && sym == last_pixel)
         run_count_next = 1'b1;
      last_pixel      = sym;
      last_pixel_seen = 1'b1;
   endfunction

   function automatic void predict_item(logic [1:0] act, logic [BYTE_W-1:0] idx,
                                        logic [PAIR_W-1:0] pair, logic [BYTE_W-1:0] code);
      logic [PAIR_W-1:0] entry;
      logic              is_index;
      rsp_item_type      run;
      item_runs.delete();
      if (act == ACT_START) begin
         clear_decode_state();
      end else if (act == ACT_LOAD) begin
         if (idx < DICT_SIZE)
            pair_table[idx] = pair;
      end else if (act == ACT_CODE && !decode_finished) begin
         if (slots_remaining == 0) begin
            // flag byte, no pixel
            flag_shift      = code;
            slots_remaining = FLAG_SLOTS;
         end else begin
            is_index        = flag_shift[BYTE_W-1];
            flag_shift      = flag_shift << 1;
            slots_remaining = slots_remaining - 1'b1;
            if (is_index) begin
               // low byte first
               entry = pair_table[int'(code) % DICT_SIZE];
               feed_symbol(entry[BYTE_W-1:0]);
               feed_symbol(entry[PAIR_W-1:BYTE_W]);
            end else begin
               feed_symbol(code);
            end
         end
      end
      foreach (item_runs[k]) begin
         run              = item_runs[k];
         run.last_of_item = (k == item_runs.size() - 1);
         pixel_runs_due.push_back(run);
      end
   endfunction

   // ---------------------------------------------------------------------
   // sender: bursts of random length, random gaps between them
   // ---------------------------------------------------------------------
   task automatic send_item(logic [1:0] act, logic [BYTE_W-1:0] idx,
                            logic [PAIR_W-1:0] pair, logic [BYTE_W-1:0] code);
      int  gap;
      bit  ignored;
      req_valid       <= 1'b1;
      req_action      <= act;
      req_entry_index <= idx;
      req_entry_pair  <= pair;
      req_code_byte   <= code;
      do @(posedge clock); while (!req_ready);
      // items the block just drops do not count toward the target
      ignored = (act == ACT_UNUSED) || (act == ACT_CODE && decode_finished);
      predict_item(act, idx, pair, code);
      if (!ignored)
         items_counted++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // don't-care fields get random values so all their bits toggle
   task automatic send_code(logic [BYTE_W-1:0] code);
      send_item(ACT_CODE, BYTE_W'($urandom), PAIR_W'($urandom), code);
   endtask

   task automatic send_load(logic [BYTE_W-1:0] idx, logic [PAIR_W-1:0] pair);
      send_item(ACT_LOAD, idx, pair, BYTE_W'($urandom));
   endtask

   task automatic send_start();
      send_item(ACT_START, BYTE_W'($urandom), PAIR_W'($urandom), BYTE_W'($urandom));
   endtask

   // hold off the sender until every predicted run has come out
   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pixel_runs_due.size() != 0)
         @(posedge clock);
      // start, load and flag items leave no run behind, so give the pipe time
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(logic [LEN_W-1:0] len);
      wait_all_results();
      csr_valid         <= 1'b1;
      csr_output_length <= len;
      do @(posedge clock); while (!csr_ready);
      out_length = len;
      csr_valid <= 1'b0;
   endtask

   // pairs with equal bytes trigger repeat counts inside one entry
   function automatic logic [PAIR_W-1:0] random_pair();
      logic [BYTE_W-1:0] lo;
      lo = BYTE_W'($urandom);
      if ($urandom_range(0, 4) < 2)
         return {lo, lo};
      return PAIR_W'($urandom);
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(0, 5))
         0:       return LEN_MIN;
         1:       return LEN_MAX;
         2, 3:    return LEN_W'($urandom_range(5, 64));
         default: return LEN_W'($urandom_range(65, 700));
      endcase
   endfunction

   // next stream byte chosen from where the decoder stands
   task automatic send_stream_byte();
      logic [BYTE_W-1:0] code;
      if (slots_remaining == 0) begin
         case ($urandom_range(0, 3))
            0:       code = 8'h00;
            1:       code = 8'hff;
            default: code = BYTE_W'($urandom);
         endcase
      end else if (flag_shift[BYTE_W-1]) begin
         // index slot: favor a few hot entries
         code = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 7)) : BYTE_W'($urandom);
      end else if (run_count_next) begin
         case ($urandom_range(0, 4))
            0:       code = 8'hff;
            1:       code = 8'h00;
            2, 3:    code = BYTE_W'($urandom_range(1, 8));
            default: code = BYTE_W'($urandom);
         endcase
      end else begin
         code = ($urandom_range(0, 2) == 0) ? last_pixel : BYTE_W'($urandom);
      end
      send_code(code);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // every entry written first, so no index byte ever reads an empty entry
   task automatic test_dictionary_fill();
      for (int e = 0; e < DICT_SIZE; e++)
         send_load(BYTE_W'(e), random_pair());
   endtask

   // literal slots, repeat counts, zero copies, clipping and bytes after done
   task automatic test_literal_runs();
      write_length(LEN_W'(16));
      send_load(8'h00, 16'h3c07);
      send_start();
      send_code(8'h00);       // flag byte, all literal slots
      send_code(8'h00);       // first pixel, no previous pixel yet
      send_code(8'h00);       // equals previous, arms a count
      send_code(8'hff);       // count adding no copies
      send_code(8'hff);
      send_code(8'hff);       // arms a count
      send_code(8'h02);       // three more copies
      send_code(8'h80);
      send_code(8'h80);       // count armed across the flag boundary
      send_code(8'hff);       // flag byte, all index slots
      send_code(8'h00);       // low byte is the count, run clipped at length
      send_code(8'h33);       // after done
   endtask

   // index slots giving two runs from one item, unused action, reload mid-decode
   task automatic test_pair_expansion();
      write_length(LEN_MAX);
      send_load(8'hff, 16'h4242);
      send_load(8'h01, 16'h10fe);
      send_start();
      send_code(8'hff);
      send_code(8'hff);       // both bytes equal, count armed
      send_code(8'h01);       // count of 0xfe, then a fresh pixel
      send_item(ACT_UNUSED, 8'hff, 16'hffff, 8'hff);
      send_load(8'h01, 16'h7700);
      send_code(8'h01);
   endtask

   // length lowered below what the open decode already produced
   task automatic test_length_lowered();
      write_length(LEN_MIN);
      send_code(8'h00);
      send_code(8'h01);
   endtask

   task automatic test_random_streams();
      int decodes;
      int n;
      decodes = 0;
      while (items_counted < ITEM_TARGET) begin
         if (decodes % 4 == 0 || $urandom_range(0, 3) == 0)
            write_length(pick_length());
         else if ($urandom_range(0, 7) == 0)
            wait_all_results();
         send_start();
         n = $urandom_range(6, 70);
         for (int k = 0; k < n && items_counted < ITEM_TARGET; k++) begin
            case ($urandom_range(0, 49))
               0, 1, 2: send_load(BYTE_W'($urandom), random_pair());
               3:       send_item(ACT_UNUSED, BYTE_W'($urandom), PAIR_W'($urandom),
                                  BYTE_W'($urandom));
               4:       send_start();
               default: send_stream_byte();
            endcase
            // mostly move on once done, sometimes keep feeding bytes
            if (decode_finished && $urandom_range(0, 3) != 0)
               break;
         end
         decodes++;
      end
   endtask

   initial begin
      clear_decode_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_dictionary_fill();
      test_literal_runs();
      test_pair_expansion();
      test_length_lowered();
      test_random_streams();
      wait_all_results();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // result checker and receiver stall pattern
   // ---------------------------------------------------------------------
   rsp_item_type oldest_run;
   int           stall_mode = STALL_NONE;
   int           stall_phase_left = 0;

   function automatic void check_field(string label, logic [BYTE_W-1:0] want,
                                       logic [BYTE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_runs_due.size() == 0) begin
            $display("%0t: result expected none actual pixel %0h count %0h",
                     $time, rsp_pixel_value, rsp_repeat_count);
            mismatch_count++;
         end else begin
            oldest_run = pixel_runs_due.pop_front();
            check_field("pixel_value", oldest_run.pixel_value, rsp_pixel_value);
            check_field("repeat_count", oldest_run.repeat_count, rsp_repeat_count);
            check_field("last_of_item", BYTE_W'(oldest_run.last_of_item),
                        BYTE_W'(rsp_last_of_item));
            check_field("decode_done", BYTE_W'(oldest_run.decode_done),
                        BYTE_W'(rsp_decode_done));
         end
      end
      // stall mode is picked anew at random whenever its phase runs out
      if (stall_phase_left == 0) begin
         stall_mode       = $urandom_range(STALL_NONE, STALL_SPARSE);
         stall_phase_left = $urandom_range(20, 150);
      end else begin
         stall_phase_left--;
      end
      case (stall_mode)
         STALL_NONE:   rsp_ready <= 1'b1;
         STALL_COIN:   rsp_ready <= $urandom_range(0, 1);
         default:      rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // ---------------------------------------------------------------------
   // watchdog: cycles with no handshake on any channel
   // ---------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
